FILE: rtl/gbtd_pkg.sv
// Shared types and constants of the gravity batch tilt detector.
// No dependencies; imported by every module of the block.
package gbtd_pkg;

	localparam int NUM_AXES  = 3;
	localparam int TIME_W    = 64;
	localparam int LEN_W     = 32;
	localparam int THR_W     = 35;
	localparam int DOT_W     = 64;
	localparam int CFG_IDX_W = 8;

	// Register indexes of the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_BATCH_LENGTH    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_THRESHOLD = CFG_IDX_W'(1);

	// Register reset values
	localparam logic [LEN_W-1:0]        BATCH_LENGTH_RST    = LEN_W'(2000000);
	localparam logic signed [THR_W-1:0] ANGLE_THRESHOLD_RST = THR_W'(5165377);

	// Sequencer states
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LOAD = 6'b000010,
		S_DIV  = 6'b000100,
		S_MUL  = 6'b001000,
		S_CMP  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	// Controls of the multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic mul_en;
		logic acc_en;
	} mac_ctrl_t;

endpackage

FILE: rtl/gbtd_div.sv
// Three-lane restoring divider: signed sums divided by an unsigned count, one bit per cycle.
// Depends on gbtd_pkg.
module gbtd_div #(
	parameter int SUM_W = 27,
	parameter int CNT_W = 11,
	parameter int Q_W   = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend [gbtd_pkg::NUM_AXES],
	input  logic [CNT_W-1:0]        divisor,
	output logic                    done,
	output logic signed [Q_W-1:0]   quotient [gbtd_pkg::NUM_AXES]
);
	import gbtd_pkg::*;

	localparam int BIT_CNT_W = $clog2(SUM_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic [CNT_W-1:0]     dvs_q;
	logic [SUM_W-1:0]     mag_q [NUM_AXES];
	logic [CNT_W-1:0]     rem_q [NUM_AXES];
	logic                 neg_q [NUM_AXES];
	logic [SUM_W-1:0]     mag_nx [NUM_AXES];
	logic [CNT_W-1:0]     rem_nx [NUM_AXES];

	// One restoring step per lane
	always_comb begin
		logic [CNT_W:0] rem_sh;
		logic           geq;
		for (int i = 0; i < NUM_AXES; i++) begin
			rem_sh    = {rem_q[i], mag_q[i][SUM_W-1]};
			geq       = rem_sh >= {1'b0, dvs_q};
			rem_nx[i] = geq ? CNT_W'(rem_sh - {1'b0, dvs_q}) : CNT_W'(rem_sh);
			mag_nx[i] = {mag_q[i][SUM_W-2:0], geq};
		end
	end

	// Control: load on start, run SUM_W steps, pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			bit_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q    <= 1'b1;
				bit_cnt_q <= '0;
			end else if (busy_q) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
				if (bit_cnt_q == BIT_CNT_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Lane datapath: magnitudes and remainders
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			for (int i = 0; i < NUM_AXES; i++) begin
				neg_q[i] <= dividend[i][SUM_W-1];
				mag_q[i] <= dividend[i][SUM_W-1] ? SUM_W'(-dividend[i]) : dividend[i];
				rem_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				mag_q[i] <= mag_nx[i];
				rem_q[i] <= rem_nx[i];
			end
		end
	end

	// Truncating quotient: sign follows the dividend
	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			quotient[i] = neg_q[i] ? Q_W'(-mag_q[i][Q_W-1:0]) : mag_q[i][Q_W-1:0];
		end
	end

	assign done = done_q;

endmodule

FILE: rtl/gbtd_mac.sv
// Shared multiplier with registered product and a 64-bit saturating accumulator.
// Depends on gbtd_pkg.
module gbtd_mac #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gbtd_pkg::mac_ctrl_t           ctrl,
	input  logic signed [SAMPLE_BITS-1:0] op_a,
	input  logic signed [SAMPLE_BITS-1:0] op_b,
	output logic signed [gbtd_pkg::DOT_W-1:0] acc
);
	import gbtd_pkg::*;

	localparam int PROD_W = 2 * SAMPLE_BITS;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [DOT_W-1:0]  acc_q;
	logic signed [DOT_W:0]    sum_c;
	logic signed [DOT_W-1:0]  sat_c;

	// Multiply stage
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= op_a * op_b;
		end
	end

	// Add with clamp to the signed 64-bit range
	always_comb begin
		sum_c = (DOT_W+1)'(acc_q) + (DOT_W+1)'(DOT_W'(prod_s1));
		if (sum_c[DOT_W] != sum_c[DOT_W-1]) begin
			sat_c = sum_c[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
		end else begin
			sat_c = sum_c[DOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= sat_c;
		end
	end

	assign acc = acc_q;

endmodule

FILE: rtl/gravity_batch_tilt_detector.sv
// Top level of the gravity batch tilt detector: sequencer, batch state, config registers.
// Depends on gbtd_pkg, gbtd_div and gbtd_mac.
//
// Usage:
//  s_axis carries one accelerometer sample per transfer (x, y, z, timestamp).
//  m_axis returns one result per sample: tilt_found and batch_closed.
//  cfg_* writes batch_length (index 0) or angle_threshold (index 1); other
//  indexes are ignored. cfg_ready is always high; write only while idle.
//  The first sample after reset opens a batch. Samples are summed per axis;
//  when elapsed time exceeds batch_length the batch closes, the mean is taken
//  by a three-lane bit-serial divider and its dot product with the reference
//  is formed by one shared multiplier, three products in turn.
// Sequence:
//  A sample that does not close a batch goes from idle through the load
//  state to the output state. A closing sample also passes the divide state,
//  where the divider runs one quotient bit per cycle over SUM_W bits (SUM_W =
//  SAMPLE_BITS + clog2(MAX_BATCH_SAMPLES + 1)), then multiply and compare;
//  the first close skips the dot product and goes from divide to compare.
//  One sample is in work at a time; s_axis_tready is low from the transfer
//  until the result has been taken, so a stalled receiver holds the input off.
// Reset: clears the batch, the reference and the registers to their defaults.
module gravity_batch_tilt_detector #(
	parameter int MAX_BATCH_SAMPLES = 1024,
	parameter int SAMPLE_BITS       = 16
) (
	input  logic clk,
	input  logic arst_n,
	// x [SAMPLE_BITS], y [SAMPLE_BITS], z [SAMPLE_BITS], sample_time [64], zero pad
	input  logic [((3*SAMPLE_BITS+gbtd_pkg::TIME_W+7)/8)*8-1:0] s_axis_tdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// tilt_found [bit 0], batch_closed [bit 1], zero pad
	output logic [7:0] m_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [gbtd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gbtd_pkg::THR_W-1:0]     cfg_data
);
	import gbtd_pkg::*;

	localparam int CNT_W = $clog2(MAX_BATCH_SAMPLES + 1);
	localparam int SUM_W = SAMPLE_BITS + CNT_W;

	state_t state_q;

	// Configuration registers
	logic [LEN_W-1:0]        len_q;
	logic signed [THR_W-1:0] thr_q;

	// Captured sample
	logic signed [SAMPLE_BITS-1:0] smp_q [NUM_AXES];
	logic [TIME_W-1:0]             time_q;

	// Batch and reference state
	logic signed [SUM_W-1:0]       sum_q [NUM_AXES];
	logic [CNT_W-1:0]              count_q;
	logic [TIME_W-1:0]             start_q;
	logic                          open_q;
	logic signed [SAMPLE_BITS-1:0] ref_q [NUM_AXES];
	logic                          ref_valid_q;

	// Result register
	logic tilt_q;
	logic closed_q;

	logic [1:0] mul_cnt_q;

	logic signed [SUM_W-1:0]       sum_nx [NUM_AXES];
	logic [CNT_W-1:0]              count_nx;
	logic [TIME_W-1:0]             start_eff;
	logic [TIME_W-1:0]             elapsed;
	logic                          close_c;
	logic                          room_c;
	logic                          div_start;
	logic                          div_done;
	logic signed [SAMPLE_BITS-1:0] mean [NUM_AXES];
	logic signed [SAMPLE_BITS-1:0] mul_a;
	logic signed [SAMPLE_BITS-1:0] mul_b;
	logic signed [DOT_W-1:0]       dot;
	logic                          below_c;
	mac_ctrl_t                     mac_ctrl;
	logic                          in_xfer;
	logic                          out_xfer;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == S_OUT);
	assign out_xfer      = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = {6'b0, closed_q, tilt_q};
	assign cfg_ready     = 1'b1;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= BATCH_LENGTH_RST;
			thr_q <= ANGLE_THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_BATCH_LENGTH) begin
				len_q <= cfg_data[LEN_W-1:0];
			end else if (cfg_index == REG_ANGLE_THRESHOLD) begin
				thr_q <= cfg_data;
			end
		end
	end

	// Input capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				smp_q[i] <= s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
			end
			time_q <= s_axis_tdata[3*SAMPLE_BITS +: TIME_W];
		end
	end

	// Accumulate and test the batch age
	always_comb begin
		start_eff = open_q ? start_q : time_q;
		elapsed   = time_q - start_eff;
		close_c   = elapsed > TIME_W'(len_q);
		room_c    = count_q < CNT_W'(MAX_BATCH_SAMPLES);
		count_nx  = room_c ? count_q + 1'b1 : count_q;
		for (int i = 0; i < NUM_AXES; i++) begin
			sum_nx[i] = room_c ? sum_q[i] + SUM_W'(smp_q[i]) : sum_q[i];
		end
	end

	assign div_start = (state_q == S_LOAD) && close_c;

	gbtd_div #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W),
		.Q_W   (SAMPLE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_nx),
		.divisor  (count_nx),
		.done     (div_done),
		.quotient (mean)
	);

	// Operand select for the shared multiplier
	always_comb begin
		unique case (mul_cnt_q)
			2'd0: begin
				mul_a = mean[0];
				mul_b = ref_q[0];
			end
			2'd1: begin
				mul_a = mean[1];
				mul_b = ref_q[1];
			end
			2'd2: begin
				mul_a = mean[2];
				mul_b = ref_q[2];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		mac_ctrl.clear  = (state_q == S_DIV) && div_done;
		mac_ctrl.mul_en = (state_q == S_MUL) && (mul_cnt_q != 2'd3);
		mac_ctrl.acc_en = (state_q == S_MUL) && (mul_cnt_q != 2'd0);
	end

	gbtd_mac #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.acc    (dot)
	);

	assign below_c = dot < DOT_W'(thr_q);

	// Sequencer and batch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			start_q     <= '0;
			open_q      <= 1'b0;
			ref_valid_q <= 1'b0;
			tilt_q      <= 1'b0;
			closed_q    <= 1'b0;
			mul_cnt_q   <= '0;
			for (int i = 0; i < NUM_AXES; i++) begin
				sum_q[i] <= '0;
				ref_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					open_q  <= 1'b1;
					start_q <= start_eff;
					count_q <= count_nx;
					for (int i = 0; i < NUM_AXES; i++) begin
						sum_q[i] <= sum_nx[i];
					end
					tilt_q   <= 1'b0;
					closed_q <= close_c;
					state_q  <= close_c ? S_DIV : S_OUT;
				end
				S_DIV: begin
					mul_cnt_q <= '0;
					if (div_done) begin
						state_q <= ref_valid_q ? S_MUL : S_CMP;
					end
				end
				S_MUL: begin
					mul_cnt_q <= mul_cnt_q + 1'b1;
					if (mul_cnt_q == 2'd3) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					// First close only latches; later closes latch on tilt
					if (!ref_valid_q || below_c) begin
						for (int i = 0; i < NUM_AXES; i++) begin
							ref_q[i] <= mean[i];
						end
						ref_valid_q <= 1'b1;
					end
					tilt_q  <= ref_valid_q && below_c;
					start_q <= time_q;
					count_q <= '0;
					for (int i = 0; i < NUM_AXES; i++) begin
						sum_q[i] <= '0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_xfer) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Checks
	a_no_accept_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("input accepted while a result is pending");

	a_tilt_needs_close: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (closed_q || !tilt_q))
		else $error("tilt reported without a batch close");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BATCH_SAMPLES))
		else $error("sample count beyond its limit");

endmodule
